// File: rtl/sbbfa_pkg.sv
// Shared types, constants and helper functions of the sector bitmap allocator.
package sbbfa_pkg;

    // Map geometry
    localparam int SECTOR_COUNT = 4096;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = SECTOR_COUNT / WORD_BITS;
    localparam int WORD_AW      = $clog2(MAP_WORDS);
    localparam int BIT_AW       = $clog2(WORD_BITS);

    // Field widths
    localparam int OP_W   = 2;
    localparam int SECT_W = 12;
    localparam int CNT_W  = 13;

    localparam logic [CNT_W-1:0] SECTOR_COUNT_C = CNT_W'(SECTOR_COUNT);
    localparam logic [CNT_W-1:0] LIMIT_RESET    = CNT_W'(SECTOR_COUNT);

    // Request codes
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST      = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH    = 2'd3;

    typedef logic [WORD_BITS-1:0] sbbfa_word_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SECT_W-1:0] first_sector;
        logic [CNT_W-1:0]  end_sector;
        logic [CNT_W-1:0]  min_run;
    } sbbfa_req_t;

    typedef struct packed {
        logic              sector_used;
        logic              found;
        logic [SECT_W-1:0] region_start;
    } sbbfa_rsp_t;

    // Per-word output of the run scanner
    typedef struct packed {
        logic              stage_vld;   // a word left the scanner this cycle
        logic              last;        // it was the last word of the search
        logic              hit;         // it holds a qualifying run
        logic [CNT_W-1:0]  len;         // shortest qualifying run, earliest
        logic [SECT_W-1:0] start;
    } sbbfa_scan_t;

    // Count of consecutive ones from bit 0 up, 0..WORD_BITS
    function automatic logic [BIT_AW:0] cto_word(input sbbfa_word_t x);
        sbbfa_word_t     z;
        logic [BIT_AW:0] n;
        z = ~x;
        n = '0;
        if (z == '0) begin
            n = (BIT_AW+1)'(WORD_BITS);
        end
        else begin
            if (z[15:0] == 16'h0) begin
                n[4] = 1'b1;
                z    = z >> 16;
            end
            if (z[7:0] == 8'h0) begin
                n[3] = 1'b1;
                z    = z >> 8;
            end
            if (z[3:0] == 4'h0) begin
                n[2] = 1'b1;
                z    = z >> 4;
            end
            if (z[1:0] == 2'h0) begin
                n[1] = 1'b1;
                z    = z >> 2;
            end
            if (z[0] == 1'b0) begin
                n[0] = 1'b1;
            end
        end
        return n;
    endfunction

    // Bit order reversal
    function automatic sbbfa_word_t rev_word(input sbbfa_word_t x);
        sbbfa_word_t r;
        for (int i = 0; i < WORD_BITS; i++) begin
            r[i] = x[WORD_BITS-1-i];
        end
        return r;
    endfunction

    // Ones from bit lo up to bit hi inclusive
    function automatic sbbfa_word_t word_mask(input logic [BIT_AW-1:0] lo,
                                              input logic [BIT_AW-1:0] hi);
        sbbfa_word_t ones;
        ones = '1;
        return (ones << lo) & (ones >> (BIT_AW'(WORD_BITS-1) - hi));
    endfunction

endpackage

// File: rtl/sbbfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sbbfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sbbfa_run_scan.sv
// Free-run scanner: per-word run extraction with carry, registered into stage B, then a min tree.
module sbbfa_run_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 in_vld,
    input  logic                                 in_last,
    input  logic [sbbfa_pkg::WORD_AW-1:0]        word,
    input  sbbfa_pkg::sbbfa_word_t               free_bits,
    input  logic [sbbfa_pkg::CNT_W-1:0]          need,
    output sbbfa_pkg::sbbfa_scan_t               res
);

    localparam int WB  = sbbfa_pkg::WORD_BITS;
    localparam int BA  = sbbfa_pkg::BIT_AW;
    localparam int CW  = sbbfa_pkg::CNT_W;
    localparam int SW  = sbbfa_pkg::SECT_W;
    localparam int LVL = sbbfa_pkg::BIT_AW;

    // Run carried over from lower words
    logic [CW-1:0] carry_len_reg, carry_len_next;
    logic [SW-1:0] carry_start_reg, carry_start_next;

    // Stage A results
    logic [BA:0]     t0;
    logic [BA:0]     top_ones;
    logic [CW-1:0]   len0;
    logic [SW-1:0]   start0;
    logic [SW-1:0]   base;
    logic [WB-1:0]   q_a;
    logic [BA:0]     lp_a [WB];

    // Stage B registers
    logic            b_vld_reg;
    logic            b_last_reg;
    logic [WB-1:0]   b_q_reg;
    logic [CW-1:0]   b_len0_reg;
    logic [SW-1:0]   b_start0_reg;
    logic [BA-1:0]   b_lenp_reg [WB];
    logic [sbbfa_pkg::WORD_AW-1:0] b_word_reg;

    // Min tree nodes
    logic            nv [LVL+1][WB];
    logic [CW-1:0]   nl [LVL+1][WB];
    logic [BA-1:0]   ni [LVL+1][WB];

    // Stage A: run starts and lengths inside the word
    always_comb
    begin
        base     = {word, BA'(0)};
        t0       = sbbfa_pkg::cto_word(free_bits);
        top_ones = sbbfa_pkg::cto_word(sbbfa_pkg::rev_word(free_bits));
        len0     = carry_len_reg + CW'(t0);
        start0   = (carry_len_reg != '0) ? carry_start_reg : base;
        // lowest run merges with the carried run
        q_a[0]   = (len0 != '0) && ((t0 != (BA+1)'(WB)) || in_last) && (len0 >= need);
        lp_a[0]  = '0;
        for (int p = 1; p < WB; p++)
        begin
            lp_a[p] = sbbfa_pkg::cto_word(free_bits >> p);
            q_a[p]  = free_bits[p] && !free_bits[p-1]
                      && (((BA+1)'(p) + lp_a[p] < (BA+1)'(WB)) || in_last)
                      && (CW'(lp_a[p]) >= need);
        end
    end

    // Carry update
    always_comb
    begin
        carry_len_next   = carry_len_reg;
        carry_start_next = carry_start_reg;
        if (clear)
        begin
            carry_len_next = '0;
        end
        else if (in_vld)
        begin
            if (t0 == (BA+1)'(WB))
            begin
                carry_len_next   = carry_len_reg + CW'(WB);
                carry_start_next = start0;
            end
            else
            begin
                carry_len_next   = CW'(top_ones);
                carry_start_next = base + SW'((BA+1)'(WB) - top_ones);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_len_reg <= '0;
            b_vld_reg     <= 1'b0;
            b_last_reg    <= 1'b0;
        end
        else
        begin
            carry_len_reg <= carry_len_next;
            b_vld_reg     <= in_vld;
            b_last_reg    <= in_vld && in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_start_reg <= carry_start_next;
        b_q_reg         <= q_a;
        b_len0_reg      <= len0;
        b_start0_reg    <= start0;
        b_word_reg      <= word;
        for (int p = 0; p < WB; p++)
        begin
            b_lenp_reg[p] <= lp_a[p][BA-1:0];
        end
    end

    // Stage B: shortest qualifying run, lower index wins ties
    always_comb
    begin
        for (int lv = 0; lv <= LVL; lv++)
        begin
            for (int k = 0; k < WB; k++)
            begin
                nv[lv][k] = 1'b0;
                nl[lv][k] = '0;
                ni[lv][k] = '0;
            end
        end
        for (int k = 0; k < WB; k++)
        begin
            nv[0][k] = b_q_reg[k];
            nl[0][k] = (k == 0) ? b_len0_reg : CW'(b_lenp_reg[k]);
            ni[0][k] = BA'(k);
        end
        for (int lv = 1; lv <= LVL; lv++)
        begin
            for (int k = 0; k < WB / 2; k++)
            begin
                if (k < (WB >> lv))
                begin
                    if (nv[lv-1][2*k] && (!nv[lv-1][2*k+1]
                                          || nl[lv-1][2*k] <= nl[lv-1][2*k+1]))
                    begin
                        nv[lv][k] = 1'b1;
                        nl[lv][k] = nl[lv-1][2*k];
                        ni[lv][k] = ni[lv-1][2*k];
                    end
                    else
                    begin
                        nv[lv][k] = nv[lv-1][2*k+1];
                        nl[lv][k] = nl[lv-1][2*k+1];
                        ni[lv][k] = ni[lv-1][2*k+1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.stage_vld = b_vld_reg;
        res.last      = b_last_reg;
        res.hit       = b_vld_reg && nv[LVL][0];
        res.len       = nl[LVL][0];
        res.start     = (ni[LVL][0] == '0) ? b_start0_reg : {b_word_reg, ni[LVL][0]};
    end

endmodule

// File: rtl/sector_bitmap_best_fit_allocator.sv
// Sector occupancy bitmap with range mark, sector test and best-fit free-run search.
//
// One request is taken when start is high and busy is low; exactly one result follows,
// shown on rsp for the single cycle in which done is high. Mark requests walk the
// 32-bit bitmap words covering the range, one read-modify-write per cycle; a search
// walks the words from the start sector up to the effective limit, one word per cycle.
// A mark with an empty range or a search starting at or past the limit answers in the
// cycle after it is taken. The bitmap reads as all free after reset with no clearing
// pass. sector_limit may be written only while no request is pending.
module sector_bitmap_best_fit_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sbbfa_pkg::sbbfa_req_t          req,
    output logic                           done,
    output sbbfa_pkg::sbbfa_rsp_t          rsp,
    input  logic                           cfg_we,
    input  logic [sbbfa_pkg::CNT_W-1:0]    cfg_wdata
);

    localparam int WA = sbbfa_pkg::WORD_AW;
    localparam int BA = sbbfa_pkg::BIT_AW;
    localparam int CW = sbbfa_pkg::CNT_W;
    localparam int SW = sbbfa_pkg::SECT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [CW-1:0] limit_reg;

    // Request context
    logic [sbbfa_pkg::OP_W-1:0] op_reg;
    logic [SW-1:0] first_reg;
    logic [SW-1:0] endm1_reg;
    logic [CW-1:0] need_reg;
    logic [WA-1:0] word_reg;

    // Read-data stage tags
    logic          a_vld_reg;
    logic          a_first_reg;
    logic          a_last_reg;
    logic [WA-1:0] a_word_reg;

    logic [sbbfa_pkg::MAP_WORDS-1:0] valid_reg;

    // Best run so far
    logic          have_reg, have_next;
    logic [CW-1:0] best_len_reg, best_len_next;
    logic [SW-1:0] best_start_reg, best_start_next;

    logic                  done_reg, done_next;
    sbbfa_pkg::sbbfa_rsp_t rsp_reg, rsp_next;

    logic          acc;
    logic          empty;
    logic [CW-1:0] lim;
    logic [CW-1:0] last_cl;
    logic [CW-1:0] first_ext;
    logic [CW-1:0] endm1_w;
    logic [WA-1:0] first_word;
    logic [WA-1:0] last_word;

    logic                   rd_en;
    logic [WA-1:0]          rd_addr;
    sbbfa_pkg::sbbfa_word_t rd_data;
    sbbfa_pkg::sbbfa_word_t a_data;
    sbbfa_pkg::sbbfa_word_t a_mask;
    logic                   wr_en;
    sbbfa_pkg::sbbfa_word_t wr_data;
    logic                   is_search;
    logic                   fin_a;
    logic                   take;
    sbbfa_pkg::sbbfa_scan_t scan;

    assign busy = (state_reg != S_IDLE);
    assign acc  = start && !busy;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Request decode at accept
    always_comb
    begin
        lim       = (limit_reg > sbbfa_pkg::SECTOR_COUNT_C) ? sbbfa_pkg::SECTOR_COUNT_C
                                                            : limit_reg;
        last_cl   = (req.end_sector > sbbfa_pkg::SECTOR_COUNT_C) ? sbbfa_pkg::SECTOR_COUNT_C
                                                                 : req.end_sector;
        first_ext = CW'(req.first_sector);
        unique case (req.op)
            sbbfa_pkg::OP_MARK_USED, sbbfa_pkg::OP_MARK_FREE:
            begin
                empty   = (last_cl <= first_ext);
                endm1_w = last_cl - CW'(1);
            end
            sbbfa_pkg::OP_TEST:
            begin
                empty   = 1'b0;
                endm1_w = first_ext;
            end
            sbbfa_pkg::OP_SEARCH:
            begin
                empty   = (first_ext >= lim);
                endm1_w = lim - CW'(1);
            end
            default:
            begin
                empty   = 1'b1;
                endm1_w = first_ext;
            end
        endcase
    end

    assign first_word = first_reg[SW-1:BA];
    assign last_word  = endm1_reg[SW-1:BA];
    assign is_search  = (op_reg == sbbfa_pkg::OP_SEARCH);

    // Bitmap storage
    assign rd_en   = (state_reg == S_WALK);
    assign rd_addr = word_reg;

    sbbfa_ram #(
        .WIDTH (sbbfa_pkg::WORD_BITS),
        .DEPTH (sbbfa_pkg::MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (a_word_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Words never written read as all free
    assign a_data = valid_reg[a_word_reg] ? rd_data : '0;
    assign a_mask = sbbfa_pkg::word_mask(a_first_reg ? first_reg[BA-1:0] : BA'(0),
                                         a_last_reg ? endm1_reg[BA-1:0] : BA'('1));

    // Mark: modify and write back; words go up so no write hits a later read
    assign wr_en   = a_vld_reg && ((op_reg == sbbfa_pkg::OP_MARK_USED)
                                   || (op_reg == sbbfa_pkg::OP_MARK_FREE));
    assign wr_data = (op_reg == sbbfa_pkg::OP_MARK_USED) ? (a_data | a_mask)
                                                         : (a_data & ~a_mask);

    sbbfa_run_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (acc),
        .in_vld    (a_vld_reg && is_search),
        .in_last   (a_last_reg),
        .word      (a_word_reg),
        .free_bits (~a_data & a_mask),
        .need      (need_reg),
        .res       (scan)
    );

    // Best-fit merge, strict compare keeps the earliest run
    always_comb
    begin
        take            = scan.hit && (!have_reg || (scan.len < best_len_reg));
        have_next       = have_reg || take;
        best_len_next   = take ? scan.len : best_len_reg;
        best_start_next = take ? scan.start : best_start_reg;
    end

    assign fin_a = a_vld_reg && a_last_reg && !is_search;

    // Sequencer and result
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (empty)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (word_reg == last_word)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (fin_a || (scan.stage_vld && scan.last))
                begin
                    state_next            = S_IDLE;
                    done_next             = 1'b1;
                    rsp_next.sector_used  = (op_reg == sbbfa_pkg::OP_TEST)
                                            && a_data[first_reg[BA-1:0]];
                    rsp_next.found        = is_search && have_next;
                    rsp_next.region_start = (is_search && have_next) ? best_start_next
                                                                     : '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= sbbfa_pkg::LIMIT_RESET;
            a_vld_reg <= 1'b0;
            valid_reg <= '0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_vld_reg <= rd_en;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                valid_reg[a_word_reg] <= 1'b1;
            end
            if (acc)
            begin
                have_reg <= 1'b0;
            end
            else
            begin
                have_reg <= have_next;
            end
        end
    end

    // Payload and context
    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        a_first_reg    <= (word_reg == first_word);
        a_last_reg     <= (word_reg == last_word);
        a_word_reg     <= word_reg;
        if (acc)
        begin
            op_reg    <= req.op;
            first_reg <= req.first_sector;
            endm1_reg <= endm1_w[SW-1:0];
            need_reg  <= req.min_run;
            word_reg  <= req.first_sector[SW-1:BA];
        end
        else if (state_reg == S_WALK)
        begin
            word_reg <= word_reg + WA'(1);
        end
    end

    // Checks
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result without a pending request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer still busy");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (a_word_reg >= first_word) && (a_word_reg <= last_word))
        else $error("bitmap write outside the marked range");

    a_found_op: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.found |-> is_search)
        else $error("found set for a non-search request");

    a_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en |-> rd_addr != a_word_reg)
        else $error("read and write of the same bitmap word in one cycle");

endmodule
